FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Types and constants shared by the deque top level and its storage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   // Action codes carried in the request
   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP       = 3'd4
   } action_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } rsp_type;

endpackage

FILE: rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// Deque storage RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_ram #(
   parameter int WIDTH = dq_pkg::DATA_W,
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values held in a ring RAM with front/count.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one transaction: an action (push front, push
//   back, pop front, pop back, dump) and a value used only by pushes.
//   rsp_valid/rsp_ready return results: status, element and a last flag.
//   Push and pop give one response, registered in the cycle after acceptance;
//   a new request is taken every cycle while responses drain.
//   A dump of N elements gives N responses, one per cycle while responses
//   are taken, elements from front to back with last on the final one; the
//   first passes through the ring RAM read register and then the response
//   register, one register more than a push.
//   Requests are held off for the whole dump walk.
//   Pop or dump on an empty queue answers status empty; a push into a full
//   queue is dropped and answered with status full. Unused action codes
//   are accepted and produce no response.
//   Reset empties the queue at once (front and count cleared); RAM contents
//   are left as they are. When rsp_ready is low the pending response holds,
//   and req_ready and the dump walk stall until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module double_ended_queue_top #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

   dq_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff;
   dq_pkg::rsp_type   rsp_data_ff, rsp_next;

   logic              slot_free;
   logic              in_dump;
   logic              req_fire;
   logic              rsp_load;
   logic              is_full;
   logic              is_empty;
   logic              push_ok;
   logic [CNT_W-1:0]  count_up;
   logic [IDX_W-1:0]  front_dec;
   logic [IDX_W-1:0]  front_inc;
   logic [IDX_W-1:0]  ptr_inc;
   logic [SUM_W-1:0]  back_sum;
   logic [IDX_W-1:0]  back_pos;

   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [dq_pkg::DATA_W-1:0] ram_wdata;
   logic                      ram_re;
   logic [IDX_W-1:0]          ram_raddr;
   logic [dq_pkg::DATA_W-1:0] ram_rdata;

   // Handshake
   assign in_dump   = (state_ff == dq_pkg::S_DUMP);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_dump && slot_free;
   assign req_fire  = req_valid && req_ready;

   // Ring index arithmetic
   assign is_full   = (count_ff == CNT_FULL);
   assign is_empty  = (count_ff == '0);
   assign count_up  = count_ff + CNT_W'(1);
   assign front_dec = (front_ff == '0) ? IDX_LAST : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_LAST) ? '0 : front_ff + IDX_W'(1);
   assign ptr_inc   = (ptr_ff == IDX_LAST) ? '0 : ptr_ff + IDX_W'(1);
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_pos  = (back_sum >= SUM_WRAP) ? IDX_W'(back_sum - SUM_WRAP)
                                             : IDX_W'(back_sum);

   assign push_ok = req_fire && !is_full &&
                    ((req_data.action == dq_pkg::ACT_PUSH_FRONT) ||
                     (req_data.action == dq_pkg::ACT_PUSH_BACK));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (req_fire && (req_data.action == dq_pkg::ACT_DUMP) && !is_empty) begin
               state_in = dq_pkg::S_DUMP;
            end
         end
         dq_pkg::S_DUMP: begin
            if (slot_free && (rem_ff == '0)) begin
               state_in = dq_pkg::S_IDLE;
            end
         end
         default: state_in = dq_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      ram_we    = 1'b0;
      ram_waddr = front_dec;
      ram_wdata = req_data.value;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff;
      rsp_load  = 1'b0;
      rsp_next  = '{status: dq_pkg::ST_OK, element: '0, last: 1'b1};

      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (dq_pkg::action_type'(req_data.action))
                  dq_pkg::ACT_PUSH_FRONT: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_next.status = dq_pkg::ST_FULL;
                     end else begin
                        front_in  = front_dec;
                        count_in  = count_up;
                        ram_we    = 1'b1;
                        ram_waddr = front_dec;
                     end
                  end
                  dq_pkg::ACT_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_next.status = dq_pkg::ST_FULL;
                     end else begin
                        count_in  = count_up;
                        ram_we    = 1'b1;
                        ram_waddr = back_pos;
                     end
                  end
                  dq_pkg::ACT_POP_FRONT: begin
                     rsp_load = 1'b1;
                     if (is_empty) begin
                        rsp_next.status = dq_pkg::ST_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  dq_pkg::ACT_POP_BACK: begin
                     rsp_load = 1'b1;
                     if (is_empty) begin
                        rsp_next.status = dq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  dq_pkg::ACT_DUMP: begin
                     if (is_empty) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = dq_pkg::ST_EMPTY;
                     end else begin
                        // Start the walk: fetch the front element
                        ram_re    = 1'b1;
                        ram_raddr = front_ff;
                        ptr_in    = front_inc;
                        rem_in    = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     // Unused codes: drop without a response
                  end
               endcase
            end
         end
         dq_pkg::S_DUMP: begin
            // Emit the fetched element and fetch the next while any remain
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_next.element = ram_rdata;
               rsp_next.last    = (rem_ff == '0);
               if (rem_ff != '0) begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_ff;
                  ptr_in    = ptr_inc;
                  rem_in    = rem_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk pointer, remaining count and response payload
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ring storage
   dq_ram #(
      .WIDTH (dq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Assertions
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL, "count exceeds depth")
   `ASSERT_ALWAYS(a_write_idle, clock, reset, !(ram_we && in_dump), "RAM write during dump")
   `ASSERT_ALWAYS(a_rem_bound, clock, reset, !in_dump || (rem_ff < count_ff), "walk past count")
   `ASSERT_IMPLIES(a_dump_holds, clock, reset, in_dump, $stable({front_ff, count_ff}), "queue moved")
   `ASSERT_IMPLIES(a_push_grows, clock, reset, push_ok, count_ff == $past(count_up), "push lost")

endmodule

FILE: test/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and dump transactions into the deque and mirrors them in a
// scoreboard that keeps its own ring copy. Each response is checked field by
// field against the oldest predicted one. Both channels idle at random, with
// one stretch at full rate. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Ring copy of the deque plus the queue of predicted responses
class deque_scoreboard;
   localparam int RING_DEPTH = dq_pkg::DEPTH_DEFAULT;

   logic signed [dq_pkg::DATA_W-1:0] ring [RING_DEPTH];
   int                               front_pos;
   int                               fill_count;
   dq_pkg::rsp_type                  predicted [$];
   int                               errors;

   function new();
      front_pos  = 0;
      fill_count = 0;
      errors     = 0;
   endfunction

   // Queue one predicted response
   function void push_predicted(dq_pkg::status_type status,
                                logic signed [dq_pkg::DATA_W-1:0] element,
                                logic last);
      dq_pkg::rsp_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      predicted.push_back(r);
   endfunction

   // Apply an accepted request to the ring copy and predict its responses
   function void note_request(dq_pkg::req_type req);
      case (req.action)
         dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
            if (fill_count >= RING_DEPTH) begin
               push_predicted(dq_pkg::ST_FULL, '0, 1'b1);
            end else begin
               if (req.action == dq_pkg::ACT_PUSH_FRONT) begin
                  front_pos       = (front_pos + RING_DEPTH - 1) % RING_DEPTH;
                  ring[front_pos] = req.value;
               end else begin
                  ring[(front_pos + fill_count) % RING_DEPTH] = req.value;
               end
               fill_count++;
               push_predicted(dq_pkg::ST_OK, '0, 1'b1);
            end
         end
         dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
            if (fill_count == 0) begin
               push_predicted(dq_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               if (req.action == dq_pkg::ACT_POP_FRONT)
                  front_pos = (front_pos + 1) % RING_DEPTH;
               fill_count--;
               push_predicted(dq_pkg::ST_OK, '0, 1'b1);
            end
         end
         dq_pkg::ACT_DUMP: begin
            if (fill_count == 0) begin
               push_predicted(dq_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < fill_count; i++)
                  push_predicted(dq_pkg::ST_OK, ring[(front_pos + i) % RING_DEPTH],
                                 logic'(i == fill_count - 1));
            end
         end
         default: begin
            // unused codes leave the queue alone and answer nothing
         end
      endcase
   endfunction

   // Compare a received response with the oldest prediction
   function void check_response(dq_pkg::rsp_type got);
      dq_pkg::rsp_type want;
      if (predicted.size() == 0) begin
         $display("%0t: unexpected response status=%0d element=%0d last=%0b",
                  $time, got.status, got.element, got.last);
         errors++;
         return;
      end
      want = predicted.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status mismatch expected=%0d actual=%0d",
                  $time, want.status, got.status);
         errors++;
      end
      if (got.element !== want.element) begin
         $display("%0t: element mismatch expected=%0d actual=%0d",
                  $time, want.element, got.element);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last mismatch expected=%0b actual=%0b",
                  $time, want.last, got.last);
         errors++;
      end
   endfunction
endclass

module double_ended_queue_top_tb;

   localparam int RANDOM_ITEMS   = 410;
   localparam int PHASE_LEN      = 40;
   localparam int IDLE_PCT       = 38;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // Weighting of the random part
   typedef enum int {
      MIX_FILL  = 0,
      MIX_DRAIN = 1,
      MIX_EVEN  = 2
   } mix_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   dq_pkg::req_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   dq_pkg::rsp_type rsp_data;

   logic            full_rate;

   deque_scoreboard sb;

   double_ended_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Record every accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_data);
   end

   // Check responses and stall the result side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
   end

   // End the run if no transaction moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // Present one request, with an optional random gap, and hold until taken
   task automatic send_request(input logic [2:0] action,
                               input logic signed [dq_pkg::DATA_W-1:0] value);
      dq_pkg::req_type r;
      r.action = action;
      r.value  = value;
      while (!full_rate && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Mostly raw random words, now and then an extreme
   function automatic logic signed [dq_pkg::DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return {1'b0, {(dq_pkg::DATA_W-1){1'b1}}};
         1:       return {1'b1, {(dq_pkg::DATA_W-1){1'b0}}};
         2:       return $urandom_range(1) ? '0 : '1;
         default: return $urandom();
      endcase
   endfunction

   // Pick an action code under the current weighting
   function automatic logic [2:0] random_action(mix_type mix);
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)
         return 3'($urandom_range(7, 5));
      if (roll < 13)
         return dq_pkg::ACT_DUMP;
      case (mix)
         MIX_FILL:  roll = (roll < 80) ? 0 : 1;
         MIX_DRAIN: roll = (roll < 33) ? 0 : 1;
         default:   roll = (roll < 56) ? 0 : 1;
      endcase
      if (roll == 0)
         return $urandom_range(1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
      return $urandom_range(1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
   endfunction

   initial begin
      int          sent;
      logic [2:0]  action;
      mix_type     mix;

      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      full_rate = 1'b0;
      sb        = new();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extreme values, unused codes, dumps
      send_request(dq_pkg::ACT_DUMP, '0);
      send_request(dq_pkg::ACT_POP_FRONT, '1);
      send_request(dq_pkg::ACT_POP_BACK, 32'sh1234_5678);
      send_request(dq_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(dq_pkg::ACT_PUSH_BACK, 32'sh8000_0000);
      send_request(dq_pkg::ACT_PUSH_FRONT, -32'sd1);
      send_request(dq_pkg::ACT_PUSH_BACK, 32'sd0);
      send_request(dq_pkg::ACT_DUMP, '1);
      send_request(3'd5, 32'sh5555_5555);
      send_request(3'd6, 32'shaaaa_aaaa);
      send_request(3'd7, '1);
      send_request(dq_pkg::ACT_POP_FRONT, '0);
      send_request(dq_pkg::ACT_DUMP, '0);
      send_request(dq_pkg::ACT_POP_BACK, '0);
      send_request(dq_pkg::ACT_DUMP, '0);
      send_request(dq_pkg::ACT_POP_BACK, '0);
      send_request(dq_pkg::ACT_POP_FRONT, '0);
      send_request(dq_pkg::ACT_DUMP, '0);

      // Random: phases that fill, drain and mix, one stretch at full rate
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mix       = mix_type'((sent / PHASE_LEN) % 3);
         full_rate <= (sent >= 200 && sent < 280);
         action    = random_action(mix);
         send_request(action, random_value());
         if (action <= dq_pkg::ACT_DUMP)
            sent++;
      end
      req_valid <= 1'b0;
      full_rate <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      @(posedge clock);
      while (sb.predicted.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.predicted.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue_top.sv
test/double_ended_queue_top_tb.sv
